// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the voice packet header parser.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPHP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VPHP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/vphp_pkg.sv =====
// ============================================================================
// Voice packet header parser package
// Constants, codes, payload types and control structs shared by the block.
// ============================================================================
`timescale 1ns / 1ps

package vphp_pkg;

    localparam int NUMBER_BITS   = 64;
    localparam int SENDER_MAX    = 32;
    localparam int MIXED_TAG_LEN = 5;
    localparam int PMATCH_W      = 3;
    localparam int SIDX_W        = $clog2(SENDER_MAX);
    localparam int SCOUNT_W      = $clog2(SENDER_MAX + 2);
    localparam int SEQ_W         = 16;
    localparam int TS_W          = 32;
    localparam int SLEN_W        = 6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_CLIENT,
        PH_MIXSEQ,
        PH_PAY_CLIENT,
        PH_PAY_MIXED,
        PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        RT_PAYLOAD,
        RT_HEADER,
        RT_SENDER,
        RT_REJECT
    } t_rtype;

    typedef enum logic {
        PT_CLIENT,
        PT_MIXED
    } t_ptype;

    typedef enum logic [1:0] {
        RC_NO_SEPARATOR,
        RC_EMPTY_SENDER,
        RC_BAD_NUMBER,
        RC_SENDER_LONG
    } t_rcode;

    typedef enum logic {
        ST_BYTE,
        ST_SENDER
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
    } t_in_item;

    typedef struct packed {
        t_rtype             result_type;
        t_ptype             packet_type;
        logic [SEQ_W-1:0]   sequence_number;
        logic [TS_W-1:0]    time_stamp;
        logic [SLEN_W-1:0]  sender_length;
        logic [7:0]         out_byte;
        t_rcode             reject_code;
        logic               packet_end;
        logic               run_last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic load_step;
        logic load_sender;
    } t_dp_cmd;

    typedef struct packed {
        logic step_valid;
        logic step_senders;
        logic sender_done;
    } t_dp_stat;

    function automatic logic [7:0] mixed_tag_byte(input logic [PMATCH_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h4D;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h58;
            3'd3:    ch = 8'h45;
            3'd4:    ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/vphp_ifs.sv =====
// ============================================================================
// Voice packet header parser channels
// Valid/ready channel interfaces for packet bytes in and results out.
// ============================================================================
`timescale 1ns / 1ps

interface vphp_in_if;
    import vphp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vphp_out_if;
    import vphp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/voice_packet_header_parser.sv =====
// ============================================================================
// Voice packet header parser
// Splits client and mixed voice packets into header, sender and payload
// results, or one reject per bad packet.
// ============================================================================
// Packet bytes arrive on i_in, one per transfer, with packet_last on the final
// byte. Results leave on o_out through a single output register.
// Each accepted byte that yields a result shows it on o_out in the next cycle.
// Header and payload bytes are taken at one byte per cycle while the output
// register is empty or being emptied in the same cycle.
// A client header that passes is followed by sender_length sender results,
// read from the sender memory one per cycle while the output register is
// empty or being emptied; no byte is taken until the last of them is loaded.
// run_last marks the final result of each byte and packet_end the final
// result of each packet; after a reject, the rest of the packet is dropped.
// Reset returns the parser to prefix matching and empties the output register.
// When the receiver stalls, the output register holds its result and i_in
// drops ready until that result is transferred.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module voice_packet_header_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vphp_in_if.sink        i_in,
    vphp_out_if.source     o_out
);
    import vphp_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_out_item w_result;
    logic      w_in_ready;
    logic      w_out_valid;

    vphp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    vphp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.data),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_result;

    `VPHP_ASSERT_IMPL(a_accept_slot_free, i_clk, i_rst_n, i_in.valid && i_in.ready, !o_out.valid || o_out.ready)
    `VPHP_ASSERT_NEXT(a_header_blocks_input, i_clk, i_rst_n, w_cmd.accept && w_stat.step_senders, !i_in.ready)
    `VPHP_ASSERT_IMPL(a_pending_run_blocks, i_clk, i_rst_n, o_out.valid && !o_out.data.run_last, !i_in.ready)
    `VPHP_ASSERT_IMPL(a_end_closes_run, i_clk, i_rst_n, o_out.valid && o_out.data.packet_end, o_out.data.run_last)

endmodule

// ===== hdl/vphp_ctrl.sv =====
// ============================================================================
// Voice packet header parser controller
// Sequences byte transfers, sender byte replay and the output register.
// ============================================================================
`timescale 1ns / 1ps

module vphp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  vphp_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output vphp_pkg::t_dp_cmd  o_cmd
);
    import vphp_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BYTE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        w_slot_free       = !r_out_valid || i_out_ready;
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        case (r_state)
            ST_BYTE: begin
                o_in_ready      = w_slot_free && i_rst_n;
                o_cmd.accept    = i_in_valid && o_in_ready;
                o_cmd.load_step = o_cmd.accept && i_stat.step_valid;
                if (o_cmd.accept && i_stat.step_senders) begin
                    n_state = ST_SENDER;
                end
            end
            ST_SENDER: begin
                o_cmd.load_sender = w_slot_free;
                if (w_slot_free && i_stat.sender_done) begin
                    n_state = ST_BYTE;
                end
            end
            default: n_state = ST_BYTE;
        endcase
        if (o_cmd.load_step || o_cmd.load_sender) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/vphp_dp.sv =====
// ============================================================================
// Voice packet header parser datapath
// Parse state, decimal accumulator, sender memory and the result register.
// ============================================================================
`timescale 1ns / 1ps

module vphp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vphp_pkg::t_in_item  i_item,
    input  vphp_pkg::t_dp_cmd   i_cmd,
    output vphp_pkg::t_dp_stat  o_stat,
    output vphp_pkg::t_out_item o_result
);
    import vphp_pkg::*;

    t_phase                r_phase, n_phase;
    logic [PMATCH_W-1:0]   r_pmatch, n_pmatch;
    logic [NUMBER_BITS-1:0] r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic                  r_nonempty, n_nonempty;
    logic                  r_fault, n_fault;
    logic [SEQ_W-1:0]      r_seq, n_seq;
    logic [1:0]            r_pipes, n_pipes;
    logic [SCOUNT_W-1:0]   r_scount, n_scount;

    logic [7:0]            r_store [SENDER_MAX];
    logic [7:0]            r_rdata;
    logic [SCOUNT_W-1:0]   r_sidx, n_sidx;
    logic [SCOUNT_W-1:0]   r_stotal;
    logic                  r_send;
    t_out_item             r_result;

    logic [7:0]            w_byte;
    logic                  w_last;
    logic                  w_is_digit;
    logic                  w_is_pipe;
    logic                  w_is_colon;
    logic [NUMBER_BITS+3:0] w_sum;
    logic                  w_dig_ovf;
    logic [NUMBER_BITS-1:0] w_dig_acc;
    logic                  w_good;
    logic                  w_tag_hit;
    logic                  w_client;
    logic                  w_wr_en;
    t_out_item             w_step;
    logic                  w_step_valid;
    logic                  w_step_senders;
    logic                  w_sender_done;
    t_out_item             w_sender_item;

    assign w_byte     = i_item.data_byte;
    assign w_last     = i_item.packet_last;
    assign w_is_digit = (w_byte >= CH_ZERO) && (w_byte <= CH_NINE);
    assign w_is_pipe  = (w_byte == CH_PIPE);
    assign w_is_colon = (w_byte == CH_COLON);
    assign w_good     = r_nonempty && !r_ovf;
    assign w_tag_hit  = (r_pmatch < PMATCH_W'(MIXED_TAG_LEN))
                        && (w_byte == mixed_tag_byte(r_pmatch));

    // Accumulator times ten plus the digit; any carry above the field width
    // means the value no longer fits.
    assign w_sum     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                       + {(NUMBER_BITS)'(0), w_byte[3:0]};
    assign w_dig_ovf = r_ovf || (w_sum[NUMBER_BITS+3:NUMBER_BITS] != 4'd0);
    assign w_dig_acc = w_dig_ovf ? r_acc : w_sum[NUMBER_BITS-1:0];

    always_comb begin
        n_phase        = r_phase;
        n_pmatch       = r_pmatch;
        n_acc          = r_acc;
        n_ovf          = r_ovf;
        n_nonempty     = r_nonempty;
        n_fault        = r_fault;
        n_seq          = r_seq;
        n_pipes        = r_pipes;
        n_scount       = r_scount;
        w_step         = '0;
        w_step_valid   = 1'b0;
        w_step_senders = 1'b0;
        w_wr_en        = 1'b0;
        w_client       = 1'b0;

        case (r_phase)
            PH_PREFIX: begin
                if (w_tag_hit) begin
                    n_pmatch = r_pmatch + 1'b1;
                    w_client = 1'b1;
                end else if ((r_pmatch >= PMATCH_W'(MIXED_TAG_LEN)) && w_is_pipe) begin
                    n_phase    = PH_MIXSEQ;
                    n_acc      = '0;
                    n_ovf      = 1'b0;
                    n_nonempty = 1'b0;
                    n_fault    = 1'b0;
                end else begin
                    n_phase  = PH_CLIENT;
                    w_client = 1'b1;
                end
            end
            PH_CLIENT: w_client = 1'b1;
            PH_MIXSEQ: begin
                if (w_is_pipe) begin
                    w_step_valid        = 1'b1;
                    w_step.packet_type  = PT_MIXED;
                    if (!r_fault && w_good) begin
                        w_step.result_type     = RT_HEADER;
                        w_step.sequence_number = r_acc[SEQ_W-1:0];
                        n_phase                = PH_PAY_MIXED;
                    end else begin
                        w_step.result_type = RT_REJECT;
                        w_step.reject_code = RC_BAD_NUMBER;
                        w_step.packet_end  = 1'b1;
                        n_phase            = PH_DISCARD;
                    end
                end else if (w_is_digit) begin
                    n_nonempty = 1'b1;
                    n_acc      = w_dig_acc;
                    n_ovf      = w_dig_ovf;
                end else begin
                    n_fault = 1'b1;
                end
            end
            PH_PAY_CLIENT: begin
                w_step_valid       = 1'b1;
                w_step.result_type = RT_PAYLOAD;
                w_step.packet_type = PT_CLIENT;
                w_step.out_byte    = w_byte;
            end
            PH_PAY_MIXED: begin
                w_step_valid       = 1'b1;
                w_step.result_type = RT_PAYLOAD;
                w_step.packet_type = PT_MIXED;
                w_step.out_byte    = w_byte;
            end
            default: ;
        endcase

        if (w_client) begin
            if (w_is_colon) begin
                w_step_valid       = 1'b1;
                w_step.packet_type = PT_CLIENT;
                w_step.result_type = RT_REJECT;
                w_step.packet_end  = 1'b1;
                n_phase            = PH_DISCARD;
                if (r_pipes < 2'd2) begin
                    w_step.reject_code = RC_NO_SEPARATOR;
                end else if (r_scount == '0) begin
                    w_step.reject_code = RC_EMPTY_SENDER;
                end else if (r_scount > SCOUNT_W'(SENDER_MAX)) begin
                    w_step.reject_code = RC_SENDER_LONG;
                end else if (r_fault || !w_good) begin
                    w_step.reject_code = RC_BAD_NUMBER;
                end else begin
                    w_step.result_type     = RT_HEADER;
                    w_step.packet_end      = 1'b0;
                    w_step.sequence_number = r_seq;
                    w_step.time_stamp      = r_acc[TS_W-1:0];
                    w_step.sender_length   = SLEN_W'(r_scount);
                    w_step_senders         = 1'b1;
                    n_phase                = PH_PAY_CLIENT;
                end
            end else if (r_pipes == 2'd0) begin
                if (w_is_pipe) begin
                    n_pipes    = 2'd1;
                    n_acc      = '0;
                    n_ovf      = 1'b0;
                    n_nonempty = 1'b0;
                end else begin
                    w_wr_en = (r_scount < SCOUNT_W'(SENDER_MAX));
                    if (r_scount <= SCOUNT_W'(SENDER_MAX)) begin
                        n_scount = r_scount + 1'b1;
                    end
                end
            end else if (r_pipes == 2'd1) begin
                if (w_is_pipe) begin
                    if (!w_good) begin
                        n_fault = 1'b1;
                    end
                    n_seq      = r_acc[SEQ_W-1:0];
                    n_pipes    = 2'd2;
                    n_acc      = '0;
                    n_ovf      = 1'b0;
                    n_nonempty = 1'b0;
                end else if (w_is_digit) begin
                    n_nonempty = 1'b1;
                    n_acc      = w_dig_acc;
                    n_ovf      = w_dig_ovf;
                end else begin
                    n_fault = 1'b1;
                end
            end else begin
                if (w_is_digit) begin
                    n_nonempty = 1'b1;
                    n_acc      = w_dig_acc;
                    n_ovf      = w_dig_ovf;
                end else begin
                    n_fault = 1'b1;
                end
            end
        end

        if (w_last) begin
            if (n_phase inside {PH_PREFIX, PH_CLIENT}) begin
                w_step_valid       = 1'b1;
                w_step.result_type = RT_REJECT;
                w_step.packet_type = PT_CLIENT;
                w_step.reject_code = RC_NO_SEPARATOR;
            end else if (n_phase == PH_MIXSEQ) begin
                w_step_valid       = 1'b1;
                w_step.result_type = RT_REJECT;
                w_step.packet_type = PT_MIXED;
                w_step.reject_code = RC_NO_SEPARATOR;
            end
            if (!w_step_senders) begin
                w_step.packet_end = 1'b1;
            end
        end
        w_step.run_last = !w_step_senders;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PREFIX;
            r_pmatch   <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_nonempty <= 1'b0;
            r_fault    <= 1'b0;
            r_seq      <= '0;
            r_pipes    <= '0;
            r_scount   <= '0;
        end else if (i_cmd.accept) begin
            if (w_last) begin
                r_phase    <= PH_PREFIX;
                r_pmatch   <= '0;
                r_acc      <= '0;
                r_ovf      <= 1'b0;
                r_nonempty <= 1'b0;
                r_fault    <= 1'b0;
                r_seq      <= '0;
                r_pipes    <= '0;
                r_scount   <= '0;
            end else begin
                r_phase    <= n_phase;
                r_pmatch   <= n_pmatch;
                r_acc      <= n_acc;
                r_ovf      <= n_ovf;
                r_nonempty <= n_nonempty;
                r_fault    <= n_fault;
                r_seq      <= n_seq;
                r_pipes    <= n_pipes;
                r_scount   <= n_scount;
            end
        end
    end

    always_comb begin
        if (i_cmd.accept && w_step_senders) begin
            n_sidx = '0;
        end else if (i_cmd.load_sender) begin
            n_sidx = r_sidx + 1'b1;
        end else begin
            n_sidx = r_sidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidx <= '0;
        end else begin
            r_sidx <= n_sidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_wr_en) begin
            r_store[r_scount[SIDX_W-1:0]] <= w_byte;
        end
        r_rdata <= r_store[n_sidx[SIDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_step_senders) begin
            r_stotal <= r_scount;
            r_send   <= w_last;
        end
    end

    assign w_sender_done = ((r_sidx + 1'b1) == r_stotal);

    always_comb begin
        w_sender_item             = '0;
        w_sender_item.result_type = RT_SENDER;
        w_sender_item.packet_type = PT_CLIENT;
        w_sender_item.out_byte    = r_rdata;
        w_sender_item.run_last    = w_sender_done;
        w_sender_item.packet_end  = w_sender_done && r_send;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_step) begin
            r_result <= w_step;
        end else if (i_cmd.load_sender) begin
            r_result <= w_sender_item;
        end
    end

    assign o_stat.step_valid   = w_step_valid;
    assign o_stat.step_senders = w_step_senders;
    assign o_stat.sender_done  = w_sender_done;
    assign o_result            = r_result;

endmodule

// ===== tb/sv/tb_voice_packet_header_parser.sv =====
// ============================================================================
// Voice packet header parser testbench
// Feeds client, mixed, malformed and noise packets byte by byte through the
// input channel, predicts every header, sender, payload and reject result
// in order, and checks each output transfer field by field. Both channels
// idle at random, the receiver also stalls for one long stretch, and the
// sender at times waits for all results before it goes on.
// ============================================================================
`timescale 1ns / 1ps

module tb_voice_packet_header_parser;
    import vphp_pkg::*;

    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_BYTES = 8;
    localparam int          LONG_HOLD    = 300;
    localparam int          HOLD_AFTER   = 40;
    localparam logic [39:0] MIXED_TAG    = "MIXED";
    localparam logic [63:0] NUM_MAX      = {64{1'b1}} >> (64 - NUMBER_BITS);

    typedef struct {
        t_in_item    item;
        int unsigned gap;
        bit          drain_first;
    } t_pending_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_hold = 1'b0;

    vphp_in_if  in_ch ();
    vphp_out_if out_ch ();

    voice_packet_header_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_pending_byte pending[$];
    t_out_item     expected_results[$];
    t_out_item     step_results[$];
    logic [7:0]    pkt_bytes[$];

    t_phase            prs_phase;
    int                tag_hits;
    logic [63:0]       num_acc;
    logic              num_ovf;
    logic              num_seen;
    logic              num_bad;
    logic [SEQ_W-1:0]  seq_saved;
    logic [1:0]        bars_seen;
    logic [7:0]        sender_mem [SENDER_MAX];
    logic [SLEN_W-1:0] sender_cnt;

    int            cycle_count = 0;
    int            mismatches = 0;
    int            results_seen = 0;
    int            bytes_accepted = 0;
    int unsigned   src_wait = 0;
    int unsigned   sink_wait = 0;
    logic          offer_valid;
    t_pending_byte next_entry;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("ERROR result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    task automatic append_byte(logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endtask

    task automatic append_step(t_out_item r);
        step_results.insert(step_results.size(), r);
    endtask

    function automatic t_out_item make_result(t_rtype rt, t_ptype pt, logic [SEQ_W-1:0] seq,
                                              logic [TS_W-1:0] ts, logic [SLEN_W-1:0] slen,
                                              logic [7:0] ob, t_rcode rc, logic pend);
        t_out_item r;
        r = '0;
        r.result_type     = rt;
        r.packet_type     = pt;
        r.sequence_number = seq;
        r.time_stamp      = ts;
        r.sender_length   = slen;
        r.out_byte        = ob;
        r.reject_code     = rc;
        r.packet_end      = pend;
        return r;
    endfunction

    task automatic parser_reset();
        prs_phase  = PH_PREFIX;
        tag_hits   = 0;
        num_acc    = '0;
        num_ovf    = 1'b0;
        num_seen   = 1'b0;
        num_bad    = 1'b0;
        seq_saved  = '0;
        bars_seen  = '0;
        sender_cnt = '0;
    endtask

    task automatic clear_number();
        num_acc  = '0;
        num_ovf  = 1'b0;
        num_seen = 1'b0;
    endtask

    task automatic take_digit(logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b} - {56'd0, CH_ZERO};
        num_seen = 1'b1;
        if (!num_ovf) begin
            if (num_acc > (NUM_MAX - d) / 64'd10) begin
                num_ovf = 1'b1;
            end else begin
                num_acc = num_acc * 64'd10 + d;
            end
        end
    endtask

    task automatic take_client_byte(logic [7:0] b);
        t_rcode code;
        int     i;
        if (b == CH_COLON) begin
            if (bars_seen < 2'd2) begin
                code = RC_NO_SEPARATOR;
            end else if (sender_cnt == '0) begin
                code = RC_EMPTY_SENDER;
            end else if (sender_cnt > SLEN_W'(SENDER_MAX)) begin
                code = RC_SENDER_LONG;
            end else if (num_bad || !num_seen || num_ovf) begin
                code = RC_BAD_NUMBER;
            end else begin
                append_step(make_result(RT_HEADER, PT_CLIENT, seq_saved,
                                        num_acc[TS_W-1:0], sender_cnt, 8'h00,
                                        RC_NO_SEPARATOR, 1'b0));
                for (i = 0; i < int'(sender_cnt); i++) begin
                    append_step(make_result(RT_SENDER, PT_CLIENT, '0, '0, '0,
                                            sender_mem[SIDX_W'(i)], RC_NO_SEPARATOR, 1'b0));
                end
                prs_phase = PH_PAY_CLIENT;
                return;
            end
            prs_phase = PH_DISCARD;
            append_step(make_result(RT_REJECT, PT_CLIENT, '0, '0, '0, 8'h00, code, 1'b1));
        end else if (bars_seen == 2'd0) begin
            if (b == CH_PIPE) begin
                bars_seen = 2'd1;
                clear_number();
            end else begin
                if (sender_cnt < SLEN_W'(SENDER_MAX)) sender_mem[sender_cnt[SIDX_W-1:0]] = b;
                if (sender_cnt <= SLEN_W'(SENDER_MAX)) sender_cnt++;
            end
        end else if (bars_seen == 2'd1 && b == CH_PIPE) begin
            if (!num_seen || num_ovf) num_bad = 1'b1;
            seq_saved = num_acc[SEQ_W-1:0];
            bars_seen = 2'd2;
            clear_number();
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            take_digit(b);
        end else begin
            num_bad = 1'b1;
        end
    endtask

    task automatic predict_byte_results(t_in_item it);
        logic [7:0] b;
        b = it.data_byte;
        step_results.delete();
        case (prs_phase)
            PH_PREFIX: begin
                if (tag_hits < MIXED_TAG_LEN && b == MIXED_TAG[39 - 8 * tag_hits -: 8]) begin
                    tag_hits++;
                    take_client_byte(b);
                end else if (tag_hits >= MIXED_TAG_LEN && b == CH_PIPE) begin
                    prs_phase = PH_MIXSEQ;
                    clear_number();
                    num_bad = 1'b0;
                end else begin
                    prs_phase = PH_CLIENT;
                    take_client_byte(b);
                end
            end
            PH_CLIENT: begin
                take_client_byte(b);
            end
            PH_MIXSEQ: begin
                if (b == CH_PIPE) begin
                    if (!num_bad && num_seen && !num_ovf) begin
                        append_step(make_result(RT_HEADER, PT_MIXED,
                                                num_acc[SEQ_W-1:0], '0, '0, 8'h00,
                                                RC_NO_SEPARATOR, 1'b0));
                        prs_phase = PH_PAY_MIXED;
                    end else begin
                        append_step(make_result(RT_REJECT, PT_MIXED, '0, '0, '0,
                                                8'h00, RC_BAD_NUMBER, 1'b1));
                        prs_phase = PH_DISCARD;
                    end
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    take_digit(b);
                end else begin
                    num_bad = 1'b1;
                end
            end
            PH_PAY_CLIENT: begin
                append_step(make_result(RT_PAYLOAD, PT_CLIENT, '0, '0, '0, b,
                                        RC_NO_SEPARATOR, 1'b0));
            end
            PH_PAY_MIXED: begin
                append_step(make_result(RT_PAYLOAD, PT_MIXED, '0, '0, '0, b,
                                        RC_NO_SEPARATOR, 1'b0));
            end
            default: begin
            end
        endcase
        if (it.packet_last) begin
            if (prs_phase == PH_PREFIX || prs_phase == PH_CLIENT) begin
                append_step(make_result(RT_REJECT, PT_CLIENT, '0, '0, '0, 8'h00,
                                        RC_NO_SEPARATOR, 1'b1));
            end else if (prs_phase == PH_MIXSEQ) begin
                append_step(make_result(RT_REJECT, PT_MIXED, '0, '0, '0, 8'h00,
                                        RC_NO_SEPARATOR, 1'b1));
            end
            if (step_results.size() != 0) begin
                step_results[step_results.size() - 1].packet_end = 1'b1;
            end
            parser_reset();
        end
        if (step_results.size() != 0) begin
            step_results[step_results.size() - 1].run_last = 1'b1;
        end
        foreach (step_results[i]) expected_results.insert(expected_results.size(),
                                                          step_results[i]);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch("result with none expected, type", 64'(got.result_type), '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.result_type !== want.result_type)
            report_mismatch("result_type", 64'(got.result_type), 64'(want.result_type));
        if (got.packet_type !== want.packet_type)
            report_mismatch("packet_type", 64'(got.packet_type), 64'(want.packet_type));
        if (got.sequence_number !== want.sequence_number)
            report_mismatch("sequence_number", 64'(got.sequence_number),
                            64'(want.sequence_number));
        if (got.time_stamp !== want.time_stamp)
            report_mismatch("time_stamp", 64'(got.time_stamp), 64'(want.time_stamp));
        if (got.sender_length !== want.sender_length)
            report_mismatch("sender_length", 64'(got.sender_length), 64'(want.sender_length));
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
        if (got.reject_code !== want.reject_code)
            report_mismatch("reject_code", 64'(got.reject_code), 64'(want.reject_code));
        if (got.packet_end !== want.packet_end)
            report_mismatch("packet_end", 64'(got.packet_end), 64'(want.packet_end));
        if (got.run_last !== want.run_last)
            report_mismatch("run_last", 64'(got.run_last), 64'(want.run_last));
    endtask

    function automatic logic [7:0] pick_sender_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_COLON || c == CH_PIPE);
        return c;
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(0, 5))
            0: return CH_PIPE;
            1: return CH_COLON;
            2: return MIXED_TAG[39 -: 8];
            3: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) append_byte(s[i]);
    endtask

    task automatic add_decimal();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: add_text("0");
            1: begin
                v = {$urandom, $urandom};
                add_text($sformatf("%0d", v));
            end
            2: add_text($sformatf("00%0d", $urandom_range(0, 999)));
            default: add_text($sformatf("%0d", $urandom_range(0, 99999)));
        endcase
    endtask

    task automatic add_payload(int n);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_client(int sender_len);
        repeat (sender_len) append_byte(pick_sender_byte());
        append_byte(CH_PIPE);
        add_decimal();
        append_byte(CH_PIPE);
        add_decimal();
        append_byte(CH_COLON);
    endtask

    task automatic build_mixed();
        add_text("MIXED|");
        add_decimal();
        append_byte(CH_PIPE);
    endtask

    task automatic queue_packet(bit burst, bit drain);
        t_pending_byte e;
        int i;
        for (i = 0; i < pkt_bytes.size(); i++) begin
            e.item.data_byte   = pkt_bytes[i];
            e.item.packet_last = (i == pkt_bytes.size() - 1);
            e.gap              = burst ? 0 : $urandom_range(0, 19);
            e.drain_first      = drain && (i == 0);
            pending.insert(pending.size(), e);
        end
        pkt_bytes.delete();
    endtask

    task automatic queue_text(string s, bit burst);
        add_text(s);
        queue_packet(burst, 1'b0);
    endtask

    task automatic queue_directed();
        add_text("MIXED|0|");
        append_byte(8'h00);
        append_byte(8'hFF);
        queue_packet(1'b1, 1'b0);
        queue_text("A|7|9:", 1'b0);
        queue_text("MIXED|18446744073709551616|", 1'b1);
        repeat (SENDER_MAX) append_byte(pick_sender_byte());
        queue_text("|1|2:", 1'b1);
        repeat (SENDER_MAX + 1) append_byte(pick_sender_byte());
        add_text("||:");
        queue_packet(1'b0, 1'b1);
        queue_text("|1|2:x", 1'b0);
        queue_text("ab|1:", 1'b1);
        queue_text("MIXE|5|6:", 1'b0);
        queue_text("ab|1|2", 1'b1);
        queue_text("MI", 1'b0);
        queue_text("MIXED|1x|", 1'b1);
        queue_text("Q|070000|1:|", 1'b0);
    endtask

    task automatic queue_random();
        int random_bytes;
        int kind;
        int k;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            kind = $urandom_range(0, 9);
            if (kind <= 7) begin
                if ($urandom_range(0, 2) == 0) begin
                    build_mixed();
                end else begin
                    build_client(($urandom_range(0, 7) == 0) ? $urandom_range(20, SENDER_MAX + 2)
                                                             : $urandom_range(1, 6));
                end
                if (kind <= 6) begin
                    add_payload($urandom_range(0, 6));
                end else if ($urandom_range(0, 1) == 0) begin
                    k = $urandom_range(0, pkt_bytes.size() - 1);
                    while (pkt_bytes.size() > k + 1) void'(pkt_bytes.pop_back());
                end else begin
                    pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = pick_noise_byte();
                    add_payload($urandom_range(0, 3));
                end
            end else begin
                repeat ($urandom_range(1, 8)) append_byte(pick_noise_byte());
            end
            random_bytes += pkt_bytes.size();
            queue_packet($urandom_range(0, 2) == 0,
                         random_bytes == pkt_bytes.size() || $urandom_range(0, 5) == 0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_wait = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_byte_results(in_ch.data);
                bytes_accepted++;
                if (pending.size() != 0) src_wait = pending[0].gap;
            end
            if (!in_ch.valid || in_ch.ready) begin
                offer_valid = 1'b0;
                if (src_wait != 0) begin
                    src_wait--;
                end else if (pending.size() != 0 &&
                             (!pending[0].drain_first || expected_results.size() == 0)) begin
                    next_entry = pending.pop_front();
                    offer_valid = 1'b1;
                    in_ch.data <= next_entry.item;
                end
                in_ch.valid <= offer_valid;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_result(out_ch.data);
                sink_wait = (((cycle_count / 700) % 3) != 0) ? $urandom_range(0, 19) : 0;
            end else if (sink_wait != 0) begin
                sink_wait--;
            end
            out_ch.ready <= (sink_wait == 0) && !sink_hold;
        end
    end

    initial begin
        wait (i_rst_n);
        while (bytes_accepted < HOLD_AFTER) @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        parser_reset();
        queue_directed();
        queue_random();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
